// ----- rtl/core/sorted_event_queue_core_macros.svh -----
`ifndef SORTED_EVENT_QUEUE_CORE_MACROS_SVH
`define SORTED_EVENT_QUEUE_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SEQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define SEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/seq_pkg.sv -----
package seq_pkg;

	localparam int DEPTH_DEFAULT = 16;

	localparam int MODE_W   = 2;
	localparam int TIME_W   = 32;
	localparam int LENGTH_W = 16;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PEEK   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0]   ev_time;
		logic                ev_kind;
		logic [LENGTH_W-1:0] ev_length;
	} seq_entry_t;

	localparam int ENTRY_W = $bits(seq_entry_t);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		seq_entry_t          head;
		logic [OCC_W-1:0]    occupancy;
	} seq_res_t;

endpackage

// ----- rtl/core/seq_ram.sv -----
module seq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/seq_ctrl.sv -----
module seq_ctrl import seq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [MODE_W-1:0]              mode,
	input  seq_entry_t                     in_entry,
	output logic                           ram_we,
	output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
	output seq_entry_t                     ram_wdata,
	output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr,
	input  seq_entry_t                     ram_rdata,
	output logic                           res_valid,
	input  logic                           res_ready,
	output seq_res_t                       res
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW:0] DEPTH_A = (AW+1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_PUT,
		S_HEAD,
		S_EMIT
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   pos_q;
	logic [MODE_W-1:0] op_q;
	seq_entry_t      new_q;
	seq_res_t        res_q;

	logic            accept;
	logic            cnt_full;
	logic            cnt_zero;
	logic [CW-1:0]   cnt_inc;
	logic [CW-1:0]   cnt_dec;
	logic [AW-1:0]   pos_last;
	logic            shift_up;

	function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] base,
			input logic [AW-1:0] idx);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, idx};
		if (s >= DEPTH_A) begin
			s = s - DEPTH_A;
		end
		return s[AW-1:0];
	endfunction

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cnt_full  = (count_q == DEPTH_C);
	assign cnt_zero  = (count_q == '0);
	assign cnt_inc   = count_q + CW'(1);
	assign cnt_dec   = count_q - CW'(1);
	assign pos_last  = AW'(count_q) - AW'(1);
	assign shift_up  = (ram_rdata.ev_time > new_q.ev_time);
	assign res_valid = (state_q == S_EMIT);
	assign res       = res_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = to_phys(head_q, pos_q);
		ram_wdata = new_q;
		ram_raddr = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && mode == MODE_INSERT && !cnt_full) begin
					if (cnt_zero) begin
						ram_we    = 1'b1;
						ram_waddr = head_q;
						ram_wdata = in_entry;
					end else begin
						ram_raddr = to_phys(head_q, pos_last);
					end
				end
			end
			S_INS: begin
				ram_we = 1'b1;
				if (shift_up) begin
					ram_wdata = ram_rdata;
					ram_raddr = to_phys(head_q, pos_q - AW'(2));
				end
			end
			S_PUT: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			pos_q   <= '0;
			op_q    <= MODE_INSERT;
			new_q   <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						new_q <= in_entry;
						op_q  <= mode;
						res_q <= '0;
						unique case (mode)
							MODE_INSERT: begin
								if (cnt_full) begin
									res_q.status    <= STATUS_FULL;
									res_q.occupancy <= OCC_W'(count_q);
									state_q         <= S_EMIT;
								end else if (cnt_zero) begin
									count_q         <= cnt_inc;
									res_q.status    <= STATUS_OK;
									res_q.occupancy <= OCC_W'(cnt_inc);
									state_q         <= S_EMIT;
								end else begin
									pos_q   <= AW'(count_q);
									state_q <= S_INS;
								end
							end
							MODE_PEEK, MODE_REMOVE: begin
								if (cnt_zero) begin
									res_q.status    <= STATUS_EMPTY;
									res_q.occupancy <= OCC_W'(count_q);
									state_q         <= S_EMIT;
								end else begin
									state_q <= S_HEAD;
								end
							end
							default: begin
								res_q.status    <= STATUS_OK;
								res_q.occupancy <= OCC_W'(count_q);
								state_q         <= S_EMIT;
							end
						endcase
					end
				end
				S_INS: begin
					if (shift_up) begin
						pos_q <= pos_q - AW'(1);
						if (pos_q == AW'(1)) begin
							state_q <= S_PUT;
						end
					end else begin
						count_q         <= cnt_inc;
						res_q.status    <= STATUS_OK;
						res_q.occupancy <= OCC_W'(cnt_inc);
						state_q         <= S_EMIT;
					end
				end
				S_PUT: begin
					count_q         <= cnt_inc;
					res_q.status    <= STATUS_OK;
					res_q.occupancy <= OCC_W'(cnt_inc);
					state_q         <= S_EMIT;
				end
				S_HEAD: begin
					res_q.status <= STATUS_OK;
					res_q.head   <= ram_rdata;
					if (op_q == MODE_REMOVE) begin
						head_q          <= to_phys(head_q, AW'(1));
						count_q         <= cnt_dec;
						res_q.occupancy <= OCC_W'(cnt_dec);
					end else begin
						res_q.occupancy <= OCC_W'(count_q);
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/seq_out.sv -----
module seq_out import seq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	output logic                res_ready,
	input  seq_res_t            res,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [TIME_W-1:0]   head_time,
	output logic                head_kind,
	output logic [LENGTH_W-1:0] head_length,
	output logic [OCC_W-1:0]    occupancy
);

	logic     valid_q;
	seq_res_t data_q;

	assign res_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			data_q <= res;
		end
	end

	assign out_valid   = valid_q;
	assign status      = data_q.status;
	assign head_time   = data_q.head.ev_time;
	assign head_kind   = data_q.head.ev_kind;
	assign head_length = data_q.head.ev_length;
	assign occupancy   = data_q.occupancy;

endmodule

// ----- rtl/core/sorted_event_queue_core.sv -----
// Accept to out_valid: full/empty/no-op and insert into an empty queue go to S_EMIT,
// peek/remove via S_HEAD, other inserts via S_INS while entries move (S_PUT if the new
// entry becomes head), then seq_out. One item at a time: next beat is taken in S_IDLE.
// Insert cost is one RAM read/write per moved entry (circular buffer, single RAM).
// arst_n clears the count, head pointer and FSM; slot contents are not cleared.
module sorted_event_queue_core import seq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [MODE_W-1:0]   mode,
	input  logic [TIME_W-1:0]   event_time,
	input  logic                event_kind,
	input  logic [LENGTH_W-1:0] event_length,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [TIME_W-1:0]   head_time,
	output logic                head_kind,
	output logic [LENGTH_W-1:0] head_length,
	output logic [OCC_W-1:0]    occupancy
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	seq_entry_t    in_entry;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	seq_entry_t    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic          res_valid;
	logic          res_ready;
	seq_res_t      res;

	assign in_entry.ev_time   = event_time;
	assign in_entry.ev_kind   = event_kind;
	assign in_entry.ev_length = event_length;

	seq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	seq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.in_entry  (in_entry),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (seq_entry_t'(ram_rdata)),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	seq_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.head_time   (head_time),
		.head_kind   (head_kind),
		.head_length (head_length),
		.occupancy   (occupancy)
	);

endmodule

// ----- rtl/core/seq_checker.sv -----
`include "sorted_event_queue_core_macros.svh"

module seq_checker import seq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic [TIME_W-1:0]   head_time,
	input logic [OCC_W-1:0]    occupancy
);

	`SEQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(occupancy), "result beat dropped or changed under stall")

	`SEQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "second beat taken while an item is in progress")

	`SEQ_ASSERT_NOW(a_empty_result, clk, arst_n, out_valid && status == STATUS_EMPTY, occupancy == '0 && head_time == '0, "empty status with nonzero occupancy or head")

	`SEQ_ASSERT_NOW(a_full_result, clk, arst_n, out_valid && status == STATUS_FULL, occupancy == OCC_W'(QUEUE_DEPTH), "full status while queue not full")

endmodule

bind sorted_event_queue_core seq_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_seq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.head_time (head_time),
	.occupancy (occupancy)
);

// ----- tb/sv/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import seq_pkg::*;

	localparam int DEPTH = DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 1850;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

	typedef struct {
		logic [MODE_W-1:0]   mode;
		logic [TIME_W-1:0]   ev_time;
		logic                ev_kind;
		logic [LENGTH_W-1:0] ev_length;
		int                  gap;
		bit                  hold;
	} sched_req_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [MODE_W-1:0]   mode = '0;
	logic [TIME_W-1:0]   event_time = '0;
	logic                event_kind = 1'b0;
	logic [LENGTH_W-1:0] event_length = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [TIME_W-1:0]   head_time;
	logic                head_kind;
	logic [LENGTH_W-1:0] head_length;
	logic [OCC_W-1:0]    occupancy;

	always #2 clk = ~clk;

	sorted_event_queue_core #(.QUEUE_DEPTH(DEPTH)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.event_time   (event_time),
		.event_kind   (event_kind),
		.event_length (event_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.head_time    (head_time),
		.head_kind    (head_kind),
		.head_length  (head_length),
		.occupancy    (occupancy)
	);

	sched_req_t pending_reqs[$];
	seq_res_t   expected_heads[$];

	// shadow copy of the sorted event store
	logic [TIME_W-1:0]   shadow_time [DEPTH];
	logic                shadow_kind [DEPTH];
	logic [LENGTH_W-1:0] shadow_len  [DEPTH];
	int                  shadow_count = 0;

	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int cycles = 0;

	function automatic seq_res_t apply_to_shadow(sched_req_t r);
		seq_res_t res;
		int pos;
		res = '0;
		res.status = STATUS_OK;
		case (r.mode)
			MODE_INSERT: begin
				if (shadow_count >= DEPTH) begin
					res.status = STATUS_FULL;
				end else begin
					pos = 0;
					while (pos < shadow_count && shadow_time[pos] <= r.ev_time)
						pos++;
					for (int i = shadow_count; i > pos; i--) begin
						shadow_time[i] = shadow_time[i-1];
						shadow_kind[i] = shadow_kind[i-1];
						shadow_len[i]  = shadow_len[i-1];
					end
					shadow_time[pos] = r.ev_time;
					shadow_kind[pos] = r.ev_kind;
					shadow_len[pos]  = r.ev_length;
					shadow_count++;
				end
			end
			MODE_PEEK, MODE_REMOVE: begin
				if (shadow_count == 0) begin
					res.status = STATUS_EMPTY;
				end else begin
					res.head.ev_time   = shadow_time[0];
					res.head.ev_kind   = shadow_kind[0];
					res.head.ev_length = shadow_len[0];
					if (r.mode == MODE_REMOVE) begin
						for (int i = 1; i < shadow_count; i++) begin
							shadow_time[i-1] = shadow_time[i];
							shadow_kind[i-1] = shadow_kind[i];
							shadow_len[i-1]  = shadow_len[i];
						end
						shadow_count--;
					end
				end
			end
			default: begin
			end
		endcase
		res.occupancy = shadow_count[OCC_W-1:0];
		return res;
	endfunction

	// mostly short, a few long
	function automatic int rand_gap();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 93)
			return $urandom_range(4, 8);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom_range(0, 7);
			4: begin
				case ($urandom_range(3))
					0: return '0;
					1: return '1;
					2: return 32'h7FFF_FFFF;
					default: return 32'h8000_0000;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic sched_req_t make_req(logic [MODE_W-1:0] m, bit calm, bit hold);
		sched_req_t r;
		r.mode    = m;
		r.ev_time = rand_time();
		r.ev_kind = 1'($urandom_range(1));
		if ($urandom_range(7) == 0)
			r.ev_length = $urandom_range(1) ? '1 : '0;
		else
			r.ev_length = LENGTH_W'($urandom);
		r.gap  = (calm || $urandom_range(1)) ? 0 : rand_gap();
		r.hold = hold;
		return r;
	endfunction

	function automatic void add_req(logic [MODE_W-1:0] m, logic [TIME_W-1:0] t, logic k,
		logic [LENGTH_W-1:0] len);
		sched_req_t r;
		r = '{mode: m, ev_time: t, ev_kind: k, ev_length: len, gap: 0, hold: 1'b0};
		pending_reqs.push_back(r);
	endfunction

	// driver
	sched_req_t cur_req;
	int idle_left = 0;
	logic drv_valid_nxt;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			drv_valid_nxt = in_valid;
			if (in_valid && !in_stall) begin
				expected_heads.push_back(apply_to_shadow(cur_req));
				beats_in++;
				drv_valid_nxt = 1'b0;
				idle_left = 0;
			end
			if (!drv_valid_nxt && pending_reqs.size() > 0) begin
				if (pending_reqs[0].hold && beats_out != beats_in) begin
					idle_left = 0;
				end else if (idle_left < pending_reqs[0].gap) begin
					idle_left++;
				end else begin
					cur_req = pending_reqs.pop_front();
					drv_valid_nxt = 1'b1;
					mode         <= cur_req.mode;
					event_time   <= cur_req.ev_time;
					event_kind   <= cur_req.ev_kind;
					event_length <= cur_req.ev_length;
				end
			end
			in_valid <= drv_valid_nxt;
		end
	end

	// monitor
	seq_res_t got_res;
	int stall_left = 0;
	int stall_phase_left = 0;
	bit stall_calm = 1'b0;
	logic mon_stall_nxt;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				beats_out <= beats_out + 1;
				if (expected_heads.size() == 0) begin
					$error("unexpected result beat: status %0h occupancy %0d", status, occupancy);
					errors++;
				end else begin
					got_res = expected_heads.pop_front();
					if (status !== got_res.status) begin
						$error("status: expected %0h got %0h", got_res.status, status);
						errors++;
					end
					if (head_time !== got_res.head.ev_time) begin
						$error("head_time: expected %0h got %0h", got_res.head.ev_time, head_time);
						errors++;
					end
					if (head_kind !== got_res.head.ev_kind) begin
						$error("head_kind: expected %0h got %0h", got_res.head.ev_kind, head_kind);
						errors++;
					end
					if (head_length !== got_res.head.ev_length) begin
						$error("head_length: expected %0h got %0h",
							got_res.head.ev_length, head_length);
						errors++;
					end
					if (occupancy !== got_res.occupancy) begin
						$error("occupancy: expected %0d got %0d", got_res.occupancy, occupancy);
						errors++;
					end
				end
			end
			if (stall_phase_left == 0) begin
				stall_calm = ($urandom_range(3) == 0);
				stall_phase_left = $urandom_range(50, 400);
			end else begin
				stall_phase_left--;
			end
			if (stall_left > 0) begin
				stall_left--;
				mon_stall_nxt = 1'b1;
			end else begin
				mon_stall_nxt = 1'b0;
				if (!stall_calm && $urandom_range(99) < 25) begin
					stall_left = rand_gap() - 1;
					mon_stall_nxt = 1'b1;
				end
			end
			out_stall <= mon_stall_nxt;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int n;
		int phase;
		int cnt;
		int pct;
		bit calm;
		bit hold;
		logic [MODE_W-1:0] m;

		// empty-queue cases, ordering extremes, equal-time stability
		add_req(MODE_PEEK, '1, 1'b1, '1);
		add_req(MODE_REMOVE, '1, 1'b1, '1);
		add_req(MODE_NOP, '0, 1'b0, '0);
		add_req(MODE_INSERT, '1, 1'b1, '1);
		add_req(MODE_INSERT, '0, 1'b0, '0);
		add_req(MODE_INSERT, '0, 1'b1, 16'd1);
		add_req(MODE_INSERT, 32'h8000_0000, 1'b0, 16'h8000);
		add_req(MODE_INSERT, 32'h7FFF_FFFF, 1'b1, 16'h7FFF);
		add_req(MODE_INSERT, '0, 1'b0, 16'd2);
		add_req(MODE_NOP, '1, 1'b1, '1);
		add_req(MODE_PEEK, '0, 1'b0, '0);
		for (int i = 0; i < 6; i++)
			add_req(MODE_REMOVE, '0, 1'b0, '0);
		add_req(MODE_REMOVE, '0, 1'b0, '0);
		add_req(MODE_INSERT, 32'd5, 1'b1, 16'hA5A5);
		add_req(MODE_PEEK, '1, 1'b1, '1);
		add_req(MODE_REMOVE, '1, 1'b0, '0);

		n = 0;
		phase = 0;
		while (n < RANDOM_ITEMS) begin
			calm = ($urandom_range(4) == 0);
			hold = (phase % 4 == 3);
			if (phase % 3 == 0) begin
				// fill past full, then drain past empty
				cnt = DEPTH + $urandom_range(1, 4);
				for (int i = 0; i < cnt; i++) begin
					m = ($urandom_range(9) == 0) ? MODE_PEEK : MODE_INSERT;
					pending_reqs.push_back(make_req(m, calm, hold && i == 0));
					n++;
				end
				cnt = DEPTH + $urandom_range(1, 3);
				for (int i = 0; i < cnt; i++) begin
					m = ($urandom_range(7) == 0) ? MODE_PEEK : MODE_REMOVE;
					pending_reqs.push_back(make_req(m, calm, 1'b0));
					n++;
				end
			end else begin
				case ($urandom_range(2))
					0: pct = 15;
					1: pct = 50;
					default: pct = 85;
				endcase
				cnt = $urandom_range(30, 150);
				for (int i = 0; i < cnt; i++) begin
					if ($urandom_range(99) < pct)
						m = MODE_INSERT;
					else begin
						case ($urandom_range(19))
							0: m = MODE_NOP;
							1, 2, 3, 4, 5, 6, 7: m = MODE_PEEK;
							default: m = MODE_REMOVE;
						endcase
					end
					pending_reqs.push_back(make_req(m, calm, hold && i == 0));
					n++;
				end
			end
			phase++;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_heads.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && expected_heads.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
